// ----- rtl/core/dns_response_address_extractor_macros.svh -----
// Assertion macros shared by the extractor RTL.
`ifndef DNS_RESPONSE_ADDRESS_EXTRACTOR_MACROS_SVH
`define DNS_RESPONSE_ADDRESS_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS

// property must hold on every clock edge outside reset
`define DRAS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("dras assertion failed");

// condition must never be seen outside reset
`define DRAS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("dras forbidden condition seen");

`else

`define DRAS_ASSERT(lbl, clk, rst_n, prop)
`define DRAS_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/dras_pkg.sv -----
`default_nettype none

package dras_pkg;

	// message byte word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} msg_word_t;

	// result word
	typedef struct packed {
		logic       kind;
		logic [7:0] addr_byte;
		logic [3:0] record_number;
		logic       record_end;
		logic [4:0] address_count;
		logic [1:0] status;
		logic       last;
	} res_word_t;

	// result kinds
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// summary status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_NONE  = 2'd1;
	localparam logic [1:0] STATUS_TRUNC = 2'd2;

	// register map (byte addresses)
	localparam int         PADDR_W          = 3;
	localparam logic [2:0] ADDR_WANTED_TYPE = 3'd0;
	localparam logic [15:0] WANTED_TYPE_RST = 16'd1;

	// byte positions inside fixed-size fields
	localparam logic [3:0] HDR_ANCOUNT_LO = 4'd7;
	localparam logic [3:0] HDR_LAST       = 4'd11;
	localparam logic [3:0] QFIX_LAST      = 4'd3;
	localparam logic [3:0] AFIX_TYPE_LO   = 4'd1;
	localparam logic [3:0] AFIX_LAST      = 4'd9;

	// first byte value that marks a compression pointer
	localparam logic [7:0] NAME_PTR_MIN = 8'd192;

	// saturation of the found-address counter
	localparam logic [4:0] FOUND_MAX = 5'd31;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = 3;
	localparam int FIFO_CNT_W = 4;
	localparam logic [FIFO_CNT_W-1:0] FIFO_STALL_ABOVE = 4'd4;

endpackage

`default_nettype wire

// ----- rtl/core/dns_response_address_extractor.sv -----
// DNS response address extractor. Feed the response message one byte per
// word on the msg channel, with end_of_packet on its final byte. The block
// walks the header, the single question and up to MAX_ANSWERS answers, and
// for each record whose type equals wanted_type (APB register at address 0,
// reset 1 = A; write 28 for AAAA) it emits every rdata byte as a data word
// tagged with its record number, record_end on the record's final byte.
// After the final byte comes one summary word with the address count and a
// status (0 ok, 1 no match, 2 message ended before the parse finished); all
// parse state then clears, so the next byte starts a new message. The block
// takes one byte per cycle while msg_stall is low, through the input register
// into the result queue. Results go through an 8-word queue; msg_stall rises
// when more than four words wait, so a back-pressured output side throttles
// the input, and a final byte with both a data word and a summary queues two
// words that leave one per pop. No clearing pass after reset.
`default_nettype none

`include "dns_response_address_extractor_macros.svh"

module dns_response_address_extractor #(
	parameter int MAX_ANSWERS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// message byte channel
	input  wire                              msg_valid,
	output logic                             msg_stall,
	input  dras_pkg::msg_word_t              msg_word,
	// result channel
	output logic                             res_valid,
	input  wire                              res_stall,
	output dras_pkg::res_word_t              res_word,
	// configuration port
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [dras_pkg::PADDR_W-1:0]     paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int CNT_W = $clog2(MAX_ANSWERS + 1);
	localparam logic [CNT_W-1:0] ANS_LIMIT = CNT_W'(MAX_ANSWERS);

	typedef enum logic [8:0] {
		PH_HEADER = 9'b000000001,
		PH_QNAME  = 9'b000000010,
		PH_QPTR   = 9'b000000100,
		PH_QFIXED = 9'b000001000,
		PH_ANAME  = 9'b000010000,
		PH_APTR   = 9'b000100000,
		PH_AFIXED = 9'b001000000,
		PH_RDATA  = 9'b010000000,
		PH_DONE   = 9'b100000000
	} phase_t;

	// ------------------------------------------------------------------
	// configuration register
	logic [15:0] wanted_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == dras_pkg::ADDR_WANTED_TYPE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= dras_pkg::WANTED_TYPE_RST;
		end else if (cfg_wr) begin
			wanted_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr == dras_pkg::ADDR_WANTED_TYPE) begin
			prdata = {16'd0, wanted_q};
		end else begin
			prdata = 32'd0;
		end
	end

	// ------------------------------------------------------------------
	// input register
	logic                msg_accept;
	logic                valid_s1;
	dras_pkg::msg_word_t word_s1;

	assign msg_accept = msg_valid && !msg_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= msg_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_accept) begin
			word_s1 <= msg_word;
		end
	end

	// ------------------------------------------------------------------
	// parse state
	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [CNT_W-1:0] limit_q, limit_d;
	logic [CNT_W-1:0] seen_q, seen_d, seen_inc;
	logic [7:0]  label_q, label_d;
	logic [7:0]  prev_q, prev_d;
	logic [15:0] rtype_q, rtype_d;
	logic [15:0] rleft_q, rleft_d;
	logic        match_q, match_d;
	logic [4:0]  found_q, found_d;

	logic [7:0]  b;
	logic        eop;
	logic [15:0] fshift;
	logic        rend;
	logic        data_push;
	logic        sum_push;
	logic [1:0]  sum_status;
	dras_pkg::res_word_t data_word;
	dras_pkg::res_word_t sum_word;

	// phase after one answer, or the question, is finished
	function automatic phase_t after_answer(input logic [CNT_W-1:0] seen,
			input logic [CNT_W-1:0] limit);
		phase_t ph;
		if (seen >= limit) begin
			ph = PH_DONE;
		end else begin
			ph = PH_ANAME;
		end
		return ph;
	endfunction

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		limit_d    = limit_q;
		seen_d     = seen_q;
		label_d    = label_q;
		prev_d     = prev_q;
		rtype_d    = rtype_q;
		rleft_d    = rleft_q;
		match_d    = match_q;
		found_d    = found_q;
		data_push  = 1'b0;
		sum_push   = 1'b0;
		sum_status = dras_pkg::STATUS_OK;

		b        = word_s1.data_byte;
		eop      = word_s1.end_of_packet;
		fshift   = {prev_q, b};
		seen_inc = seen_q + 1'b1;
		rend     = (rleft_q <= 16'd1);

		if (valid_s1) begin
			prev_d = b;
			case (phase_q)
				PH_HEADER: begin
					// answer count sits in header bytes 6 and 7
					if (pos_q == dras_pkg::HDR_ANCOUNT_LO) begin
						if (fshift < 16'(MAX_ANSWERS)) begin
							limit_d = fshift[CNT_W-1:0];
						end else begin
							limit_d = ANS_LIMIT;
						end
					end
					if (pos_q >= dras_pkg::HDR_LAST) begin
						phase_d = PH_QNAME;
						label_d = 8'd0;
						pos_d   = 4'd0;
					end else begin
						pos_d = pos_q + 1'b1;
					end
				end
				PH_QNAME, PH_ANAME: begin
					// label-wise name walk
					if (label_q != 8'd0) begin
						label_d = label_q - 1'b1;
					end else if (b == 8'd0) begin
						phase_d = (phase_q == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
						pos_d   = 4'd0;
					end else if (b >= dras_pkg::NAME_PTR_MIN) begin
						phase_d = (phase_q == PH_QNAME) ? PH_QPTR : PH_APTR;
					end else begin
						label_d = b;
					end
				end
				PH_QPTR: begin
					phase_d = PH_QFIXED;
					pos_d   = 4'd0;
				end
				PH_APTR: begin
					phase_d = PH_AFIXED;
					pos_d   = 4'd0;
				end
				PH_QFIXED: begin
					if (pos_q >= dras_pkg::QFIX_LAST) begin
						label_d = 8'd0;
						pos_d   = 4'd0;
						phase_d = after_answer(seen_q, limit_q);
					end else begin
						pos_d = pos_q + 1'b1;
					end
				end
				PH_AFIXED: begin
					// type, class, ttl, rdlength
					if (pos_q == dras_pkg::AFIX_TYPE_LO) begin
						rtype_d = fshift;
					end
					if (pos_q >= dras_pkg::AFIX_LAST) begin
						rleft_d = fshift;
						match_d = (rtype_q == wanted_q);
						if (fshift == 16'd0) begin
							seen_d  = seen_inc;
							label_d = 8'd0;
							pos_d   = 4'd0;
							phase_d = after_answer(seen_inc, limit_q);
						end else begin
							phase_d = PH_RDATA;
						end
					end else begin
						pos_d = pos_q + 1'b1;
					end
				end
				PH_RDATA: begin
					data_push = match_q;
					if (rend) begin
						rleft_d = 16'd0;
						if (match_q && (found_q < dras_pkg::FOUND_MAX)) begin
							found_d = found_q + 1'b1;
						end
						seen_d  = seen_inc;
						label_d = 8'd0;
						pos_d   = 4'd0;
						phase_d = after_answer(seen_inc, limit_q);
					end else begin
						rleft_d = rleft_q - 1'b1;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase

			// summary, then start over
			if (eop) begin
				sum_push = 1'b1;
				if (phase_d != PH_DONE) begin
					sum_status = dras_pkg::STATUS_TRUNC;
				end else if (found_d == 5'd0) begin
					sum_status = dras_pkg::STATUS_NONE;
				end else begin
					sum_status = dras_pkg::STATUS_OK;
				end
			end
		end

		data_word.kind          = dras_pkg::KIND_DATA;
		data_word.addr_byte     = b;
		data_word.record_number = found_q[3:0];
		data_word.record_end    = rend;
		data_word.address_count = 5'd0;
		data_word.status        = dras_pkg::STATUS_OK;
		data_word.last          = !eop;

		sum_word.kind          = dras_pkg::KIND_SUMMARY;
		sum_word.addr_byte     = 8'd0;
		sum_word.record_number = 4'd0;
		sum_word.record_end    = 1'b0;
		sum_word.address_count = found_d;
		sum_word.status        = sum_status;
		sum_word.last          = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 4'd0;
			limit_q <= '0;
			seen_q  <= '0;
			label_q <= 8'd0;
			prev_q  <= 8'd0;
			rtype_q <= 16'd0;
			rleft_q <= 16'd0;
			match_q <= 1'b0;
			found_q <= 5'd0;
		end else if (valid_s1 && eop) begin
			phase_q <= PH_HEADER;
			pos_q   <= 4'd0;
			limit_q <= '0;
			seen_q  <= '0;
			label_q <= 8'd0;
			prev_q  <= 8'd0;
			rtype_q <= 16'd0;
			rleft_q <= 16'd0;
			match_q <= 1'b0;
			found_q <= 5'd0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			limit_q <= limit_d;
			seen_q  <= seen_d;
			label_q <= label_d;
			prev_q  <= prev_d;
			rtype_q <= rtype_d;
			rleft_q <= rleft_d;
			match_q <= match_d;
			found_q <= found_d;
		end
	end

	// ------------------------------------------------------------------
	// result queue: up to two words pushed per cycle, one popped
	dras_pkg::res_word_t fifo_q [dras_pkg::FIFO_DEPTH];
	logic [dras_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [dras_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic [1:0]                      push_n;
	logic                            pop;
	dras_pkg::res_word_t             first_word;

	assign push_n     = {1'b0, data_push} + {1'b0, sum_push};
	assign first_word = data_push ? data_word : sum_word;
	assign pop        = res_valid && !res_stall;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_q] <= first_word;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_q + 1'b1] <= sum_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + dras_pkg::FIFO_PTR_W'(push_n);
			rd_q  <= rd_q + dras_pkg::FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + dras_pkg::FIFO_CNT_W'(push_n) - dras_pkg::FIFO_CNT_W'(pop);
		end
	end

	assign res_valid = (cnt_q != '0);
	assign res_word  = fifo_q[rd_q];
	// room for the word in s1 and one more accepted now
	assign msg_stall = (cnt_q > dras_pkg::FIFO_STALL_ABOVE);

	// ------------------------------------------------------------------
	// checks
	`DRAS_NEVER(a_fifo_overflow, clk, arst_n, cnt_q > dras_pkg::FIFO_CNT_W'(dras_pkg::FIFO_DEPTH))
	`DRAS_NEVER(a_data_outside_rdata, clk, arst_n, data_push && (phase_q != PH_RDATA))
	`DRAS_ASSERT(a_eop_restarts, clk, arst_n, (valid_s1 && eop) |=> (phase_q == PH_HEADER))
	`DRAS_NEVER(a_seen_over_limit, clk, arst_n, seen_q > limit_q)
	`DRAS_NEVER(a_found_over_seen, clk, arst_n, 7'(found_q) > 7'(seen_q))

endmodule

`default_nettype wire
